@@ hdl/delm_pkg.sv @@
// Shared constants, types and stage record for the dual envelope level mixer.
package delm_pkg;

   localparam int LEVEL_W     = 7;
   localparam int NUM_LEVELS  = 4;
   localparam int NUM_SOURCES = 4;
   localparam int SEL_W       = 2;
   localparam int METHOD_W    = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4;
   localparam int NUM_W       = 2 * LEVEL_W;
   localparam int DEN_W       = LEVEL_W + 1;
   localparam int SQ_W        = 2 * LEVEL_W;
   localparam int SQ_REM_W    = LEVEL_W + 1;
   localparam int ROOT_STEPS  = LEVEL_W;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_ENABLED   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_METHOD        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_A      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_B      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECT_SOURCE = 3'd4;

   localparam logic [METHOD_W-1:0] METHOD_PLUS  = 4'd0;
   localparam logic [METHOD_W-1:0] METHOD_MINUS = 4'd1;
   localparam logic [METHOD_W-1:0] METHOD_PECK  = 4'd2;
   localparam logic [METHOD_W-1:0] METHOD_SHAV  = 4'd3;
   localparam logic [METHOD_W-1:0] METHOD_SQAR  = 4'd4;
   localparam logic [METHOD_W-1:0] METHOD_BABS  = 4'd5;
   localparam logic [METHOD_W-1:0] METHOD_TABS  = 4'd6;
   localparam logic [METHOD_W-1:0] METHOD_MULT  = 4'd7;
   localparam logic [METHOD_W-1:0] METHOD_DIVI  = 4'd8;
   localparam logic [METHOD_W-1:0] METHOD_AVG   = 4'd9;
   localparam logic [METHOD_W-1:0] METHOD_XABS  = 4'd10;
   localparam logic [METHOD_W-1:0] METHOD_MAXX  = 4'd11;
   localparam logic [METHOD_W-1:0] METHOD_MINN  = 4'd12;
   localparam logic [METHOD_W-1:0] METHOD_XORR  = 4'd13;

   typedef logic [NUM_LEVELS-1:0][LEVEL_W-1:0] delm_levels_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE,
      KIND_DIV,
      KIND_SQRT
   } delm_kind_type;

   typedef struct packed {
      logic                mix_enabled;
      logic [METHOD_W-1:0] method;
      logic [SEL_W-1:0]    source_a;
      logic [SEL_W-1:0]    source_b;
      logic [SEL_W-1:0]    direct_source;
   } delm_cfg_type;

   typedef struct packed {
      delm_kind_type       kind;
      logic                force_max;
      logic [LEVEL_W-1:0]  simple;
      logic [DEN_W-1:0]    div_den;
      logic [DEN_W-1:0]    div_rem;
      logic [LEVEL_W-1:0]  div_num;
      logic [LEVEL_W-1:0]  div_quo;
      logic [SQ_W-1:0]     sq_bits;
      logic [SQ_REM_W-1:0] sq_rem;
      logic [LEVEL_W-1:0]  sq_root;
   } delm_stage_type;

endpackage

@@ hdl/delm_front.sv @@
// Front stage: operand selection, simple operators and divider/root setup.
module delm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  delm_pkg::delm_levels_type levels,
   input  delm_pkg::delm_cfg_type   cfg,
   input  logic                     down_ready,
   output logic                     up_ready,
   output logic                     out_valid,
   output delm_pkg::delm_stage_type out_stage
);

   logic                          valid_ff;
   delm_pkg::delm_stage_type      stage_ff;
   delm_pkg::delm_stage_type      stage_in;

   logic [delm_pkg::LEVEL_W-1:0]  op_a;
   logic [delm_pkg::LEVEL_W-1:0]  op_b;
   logic [delm_pkg::LEVEL_W-1:0]  op_d;
   logic [delm_pkg::LEVEL_W:0]    sum_ab;
   logic                          a_gt_b;
   logic                          b_gt_a;
   logic [delm_pkg::LEVEL_W-1:0]  diff_ab;
   logic [delm_pkg::LEVEL_W-1:0]  diff_ba;
   logic [delm_pkg::NUM_W-1:0]    prod_ab;
   logic [delm_pkg::SQ_W:0]       sq_sum;
   logic [delm_pkg::NUM_W-1:0]    num;
   logic [delm_pkg::DEN_W-1:0]    den;
   logic                          div_sat;

   function automatic logic [delm_pkg::LEVEL_W-1:0] pick_level(
      input delm_pkg::delm_levels_type lv,
      input logic [delm_pkg::SEL_W-1:0] idx
   );
      logic [delm_pkg::LEVEL_W-1:0] r;
      r = '0;
      if (int'(idx) < delm_pkg::NUM_SOURCES && int'(idx) < delm_pkg::NUM_LEVELS) begin
         r = lv[idx];
      end
      return r;
   endfunction

   always_comb begin
      op_a    = pick_level(levels, cfg.source_a);
      op_b    = pick_level(levels, cfg.source_b);
      op_d    = pick_level(levels, cfg.direct_source);
      sum_ab  = {1'b0, op_a} + {1'b0, op_b};
      a_gt_b  = op_a > op_b;
      b_gt_a  = op_b > op_a;
      diff_ab = op_a - op_b;
      diff_ba = op_b - op_a;
      prod_ab = op_a * op_b;
      sq_sum  = (delm_pkg::SQ_W + 1)'(op_a * op_a) + (delm_pkg::SQ_W + 1)'(op_b * op_b);
      num     = '0;
      den     = '0;

      stage_in           = '0;
      stage_in.kind      = delm_pkg::KIND_SIMPLE;
      stage_in.sq_bits   = sq_sum[delm_pkg::SQ_W-1:0];

      case (cfg.method)
         delm_pkg::METHOD_PLUS: begin
            stage_in.simple = sum_ab[delm_pkg::LEVEL_W] ? delm_pkg::LEVEL_MAX
                                                        : sum_ab[delm_pkg::LEVEL_W-1:0];
         end
         delm_pkg::METHOD_MINUS: begin
            stage_in.simple = a_gt_b ? diff_ab : '0;
         end
         delm_pkg::METHOD_PECK: begin
            stage_in.simple = b_gt_a ? diff_ba : '0;
         end
         delm_pkg::METHOD_SHAV: begin
            if (a_gt_b) begin
               stage_in.kind = delm_pkg::KIND_DIV;
               num = delm_pkg::NUM_W'(diff_ab);
               den = delm_pkg::DEN_W'(10);
            end
         end
         delm_pkg::METHOD_SQAR: begin
            stage_in.kind      = delm_pkg::KIND_SQRT;
            stage_in.force_max = sq_sum[delm_pkg::SQ_W];
         end
         delm_pkg::METHOD_BABS: begin
            if (op_b != '0) begin
               stage_in.kind = delm_pkg::KIND_DIV;
               num = delm_pkg::NUM_W'(op_a);
               den = delm_pkg::DEN_W'(op_b);
            end
         end
         delm_pkg::METHOD_TABS: begin
            if (op_b != '0) begin
               stage_in.kind = delm_pkg::KIND_DIV;
               num = delm_pkg::NUM_W'({op_a, 3'b000}) + delm_pkg::NUM_W'({op_a, 1'b0});
               den = delm_pkg::DEN_W'(op_b);
            end
         end
         delm_pkg::METHOD_MULT: begin
            stage_in.kind = delm_pkg::KIND_DIV;
            num = prod_ab;
            den = delm_pkg::DEN_W'(delm_pkg::LEVEL_MAX);
         end
         delm_pkg::METHOD_DIVI: begin
            stage_in.kind = delm_pkg::KIND_DIV;
            num = {op_a, {delm_pkg::LEVEL_W{1'b0}}} - delm_pkg::NUM_W'(op_a);
            den = delm_pkg::DEN_W'(op_b) + delm_pkg::DEN_W'(1);
         end
         delm_pkg::METHOD_AVG: begin
            stage_in.simple = sum_ab[delm_pkg::LEVEL_W:1];
         end
         delm_pkg::METHOD_XABS: begin
            stage_in.simple = a_gt_b ? diff_ab : diff_ba;
         end
         delm_pkg::METHOD_MAXX: begin
            stage_in.simple = a_gt_b ? op_a : op_b;
         end
         delm_pkg::METHOD_MINN: begin
            stage_in.simple = b_gt_a ? op_a : op_b;
         end
         delm_pkg::METHOD_XORR: begin
            stage_in.simple = op_a ^ op_b;
         end
         default: begin
            stage_in.simple = '0;
         end
      endcase

      // quotient above 7 bits saturates
      div_sat = {1'b0, num} >= {den, {delm_pkg::LEVEL_W{1'b0}}};
      if (stage_in.kind == delm_pkg::KIND_DIV) begin
         stage_in.force_max = div_sat;
      end
      stage_in.div_den = den;
      stage_in.div_rem = delm_pkg::DEN_W'(num[delm_pkg::NUM_W-1:delm_pkg::LEVEL_W]);
      stage_in.div_num = num[delm_pkg::LEVEL_W-1:0];

      if (!cfg.mix_enabled) begin
         stage_in.kind      = delm_pkg::KIND_SIMPLE;
         stage_in.force_max = 1'b0;
         stage_in.simple    = op_d;
      end
   end

   assign up_ready  = !valid_ff || down_ready;
   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

endmodule

@@ hdl/delm_step.sv @@
// One pipeline stage: a restoring divide step and a restoring square root step.
module delm_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  delm_pkg::delm_stage_type in_stage,
   input  logic                     down_ready,
   output logic                     up_ready,
   output logic                     out_valid,
   output delm_pkg::delm_stage_type out_stage
);

   logic                           valid_ff;
   delm_pkg::delm_stage_type       stage_ff;
   delm_pkg::delm_stage_type       stage_in;

   logic [delm_pkg::DEN_W:0]       div_acc;
   logic [delm_pkg::DEN_W:0]       div_diff;
   logic                           div_ge;
   logic [delm_pkg::SQ_REM_W+1:0]  sq_acc;
   logic [delm_pkg::SQ_REM_W+1:0]  sq_trial;
   logic [delm_pkg::SQ_REM_W+1:0]  sq_diff;
   logic                           sq_ge;

   always_comb begin
      stage_in = in_stage;

      div_acc  = {in_stage.div_rem, in_stage.div_num[delm_pkg::LEVEL_W-1]};
      div_diff = div_acc - {1'b0, in_stage.div_den};
      div_ge   = div_acc >= {1'b0, in_stage.div_den};
      stage_in.div_rem = div_ge ? div_diff[delm_pkg::DEN_W-1:0]
                                : div_acc[delm_pkg::DEN_W-1:0];
      stage_in.div_num = {in_stage.div_num[delm_pkg::LEVEL_W-2:0], 1'b0};
      stage_in.div_quo = {in_stage.div_quo[delm_pkg::LEVEL_W-2:0], div_ge};

      sq_acc   = {in_stage.sq_rem, in_stage.sq_bits[delm_pkg::SQ_W-1 -: 2]};
      sq_trial = {1'b0, in_stage.sq_root, 2'b01};
      sq_diff  = sq_acc - sq_trial;
      sq_ge    = sq_acc >= sq_trial;
      stage_in.sq_rem  = sq_ge ? sq_diff[delm_pkg::SQ_REM_W-1:0]
                               : sq_acc[delm_pkg::SQ_REM_W-1:0];
      stage_in.sq_bits = {in_stage.sq_bits[delm_pkg::SQ_W-3:0], 2'b00};
      stage_in.sq_root = {in_stage.sq_root[delm_pkg::LEVEL_W-2:0], sq_ge};
   end

   assign up_ready  = !valid_ff || down_ready;
   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff && stage_ff.kind == delm_pkg::KIND_DIV && !stage_ff.force_max
      |-> stage_ff.div_rem < stage_ff.div_den)
      else $error("divider remainder not below divisor");

   a_sqrt_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff && stage_ff.kind == delm_pkg::KIND_SQRT
      |-> stage_ff.sq_rem <= {stage_ff.sq_root, 1'b0})
      else $error("root remainder above twice the partial root");

endmodule

@@ hdl/dual_envelope_level_mixer.sv @@
// Top level of the dual envelope level mixer: config registers, pipeline and output register.
// Takes one request per cycle when the result side keeps up; each result passes through the
// front stage, seven divide/root stages that each settle one quotient bit and one root bit,
// and one output register, in that order. A stalled result does not block intake until every
// stage holds a request. Configuration writes take effect on the next accepted request and are
// meant to happen only while the pipeline is empty.
module dual_envelope_level_mixer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [delm_pkg::LEVEL_W-1:0]        req_level_0,
   input  logic [delm_pkg::LEVEL_W-1:0]        req_level_1,
   input  logic [delm_pkg::LEVEL_W-1:0]        req_level_2,
   input  logic [delm_pkg::LEVEL_W-1:0]        req_level_3,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [delm_pkg::LEVEL_W-1:0]        rsp_mixed_level,
   input  logic                                csr_write_enable,
   input  logic [delm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [delm_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int STEPS = delm_pkg::ROOT_STEPS;

   delm_pkg::delm_cfg_type          cfg_ff;
   delm_pkg::delm_levels_type       levels;

   logic [STEPS:0]                  chain_valid;
   logic [STEPS:0]                  chain_ready;
   delm_pkg::delm_stage_type        chain_stage [STEPS+1];

   logic                            rsp_valid_ff;
   logic [delm_pkg::LEVEL_W-1:0]    rsp_level_ff;
   logic [delm_pkg::LEVEL_W-1:0]    rsp_level_in;
   logic                            out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mix_enabled   <= 1'b0;
         cfg_ff.method        <= delm_pkg::METHOD_PLUS;
         cfg_ff.source_a      <= delm_pkg::SEL_W'(0);
         cfg_ff.source_b      <= delm_pkg::SEL_W'(1);
         cfg_ff.direct_source <= delm_pkg::SEL_W'(0);
      end else if (csr_write_enable) begin
         case (csr_index)
            delm_pkg::CSR_MIX_ENABLED: begin
               cfg_ff.mix_enabled <= csr_write_data[0];
            end
            delm_pkg::CSR_METHOD: begin
               cfg_ff.method <= csr_write_data[delm_pkg::METHOD_W-1:0];
            end
            delm_pkg::CSR_SOURCE_A: begin
               cfg_ff.source_a <= csr_write_data[delm_pkg::SEL_W-1:0];
            end
            delm_pkg::CSR_SOURCE_B: begin
               cfg_ff.source_b <= csr_write_data[delm_pkg::SEL_W-1:0];
            end
            delm_pkg::CSR_DIRECT_SOURCE: begin
               cfg_ff.direct_source <= csr_write_data[delm_pkg::SEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign levels = {req_level_3, req_level_2, req_level_1, req_level_0};

   delm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .levels     (levels),
      .cfg        (cfg_ff),
      .down_ready (chain_ready[0]),
      .up_ready   (req_ready),
      .out_valid  (chain_valid[0]),
      .out_stage  (chain_stage[0])
   );

   for (genvar i = 1; i <= STEPS; i++) begin : g_step
      delm_step u_step (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (chain_valid[i-1]),
         .in_stage   (chain_stage[i-1]),
         .down_ready (chain_ready[i]),
         .up_ready   (chain_ready[i-1]),
         .out_valid  (chain_valid[i]),
         .out_stage  (chain_stage[i])
      );
   end

   assign out_ready          = !rsp_valid_ff || rsp_ready;
   assign chain_ready[STEPS] = out_ready;

   always_comb begin
      case (chain_stage[STEPS].kind)
         delm_pkg::KIND_DIV: begin
            rsp_level_in = chain_stage[STEPS].force_max ? delm_pkg::LEVEL_MAX
                                                        : chain_stage[STEPS].div_quo;
         end
         delm_pkg::KIND_SQRT: begin
            rsp_level_in = chain_stage[STEPS].force_max ? delm_pkg::LEVEL_MAX
                                                        : chain_stage[STEPS].sq_root;
         end
         default: begin
            rsp_level_in = chain_stage[STEPS].simple;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= chain_valid[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && chain_valid[STEPS]) begin
         rsp_level_ff <= rsp_level_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mixed_level = rsp_level_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&chain_valid) && rsp_valid_ff && !rsp_ready)
      else $error("request refused while the pipeline has a free stage");

   a_last_stage_drains: assert property (@(posedge clock) disable iff (reset)
      chain_valid[STEPS] && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("finished request not moved into the output register");

endmodule
